[hw/rtl/mhpq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared widths, defaults and status codes of the max-heap priority queue.
// ----------------------------------------------------------------------------
package mhpq_pkg;

    localparam int DEFAULT_CAPACITY = 64;

    localparam int PRIO_W   = 16;
    localparam int TAG_W    = 16;
    localparam int ENTRY_W  = PRIO_W + TAG_W;
    localparam int STATUS_W = 2;
    localparam int HELD_W   = 7;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    localparam logic REQ_INSERT  = 1'b0;
    localparam logic REQ_EXTRACT = 1'b1;

endpackage

[hw/rtl/max_heap_priority_queue_top.sv]
`timescale 1ns / 1ps
// An insert writes its entry at the end and then rebuilds the heap; an extract reads
// the root, shifts every later entry down one place and then rebuilds. The rebuild
// sifts down each node from (n-2)/2 to 0, where n is the count after the request.
// Throughput: one transaction at a time; the single-read-port heap memory sets it.
// Rejected requests (full or empty) go straight to the finish state without touching the memory.
// Reset: rst_n clears the entry count and the control state; the memory is not cleared.
// ----------------------------------------------------------------------------
// max_heap_priority_queue_top
// Binary max-heap priority queue held in one synchronous memory. Each request
// not rejected appends or extracts-and-shifts, then the heap is rebuilt bottom-up.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_top
    import mhpq_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                req_valid,
    output logic                req_stall,
    input  logic                req_type,
    input  logic [PRIO_W-1:0]   entry_priority,
    input  logic [TAG_W-1:0]    entry_tag,

    output logic                rsp_valid,
    input  logic                rsp_stall,
    output logic [STATUS_W-1:0] status,
    output logic [PRIO_W-1:0]   out_priority,
    output logic [TAG_W-1:0]    out_tag,
    output logic [HELD_W-1:0]   entries_held
);

    // Count needs to hold CAPACITY itself; addresses only reach CAPACITY-1.
    // Child indices of the deepest node run up to 2*CAPACITY, hence two extra bits.
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int IDX_W  = ADDR_W + 2;

    // The sequencer walks through the request in phases. Each sift level
    // needs up to three memory reads (node on the first level only, left, right)
    // because the memory has one read port.
    typedef enum logic [10:0] {
        ST_IDLE   = 11'b00000000001,
        ST_EX_LAT = 11'b00000000010,
        ST_SH_RD  = 11'b00000000100,
        ST_SH_WR  = 11'b00000001000,
        ST_RB_GO  = 11'b00000010000,
        ST_SD_RDN = 11'b00000100000,
        ST_SD_RDL = 11'b00001000000,
        ST_SD_RDR = 11'b00010000000,
        ST_SD_CMP = 11'b00100000000,
        ST_FIN    = 11'b01000000000,
        ST_SPARE  = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    // Heap memory: one write port, one registered read port.
    logic [ENTRY_W-1:0] heap_mem [CAPACITY];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               mem_rd_en;
    logic [ADDR_W-1:0]  mem_rd_addr;
    logic               mem_wr_en;
    logic [ADDR_W-1:0]  mem_wr_addr;
    logic [ENTRY_W-1:0] mem_wr_data;

    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    shift_idx_reg, shift_idx_next;
    logic [ADDR_W-1:0]   node_reg, node_next;     // current position of the sifted value
    logic [ADDR_W-1:0]   root_reg, root_next;     // node whose sift-down is running
    logic                first_reg, first_next;   // first level of this sift
    logic                right_ok_reg, right_ok_next;
    logic [ENTRY_W-1:0]  val_reg, val_next;       // value travelling down
    logic [ENTRY_W-1:0]  left_reg, left_next;

    logic [STATUS_W-1:0] op_status_reg, op_status_next;
    logic [PRIO_W-1:0]   op_prio_reg, op_prio_next;
    logic [TAG_W-1:0]    op_tag_reg, op_tag_next;

    logic                rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0] rsp_status_reg, rsp_status_next;
    logic [PRIO_W-1:0]   rsp_prio_reg, rsp_prio_next;
    logic [TAG_W-1:0]    rsp_tag_reg, rsp_tag_next;
    logic [HELD_W-1:0]   rsp_held_reg, rsp_held_next;

    logic               req_accept;
    logic               rsp_free;
    logic [IDX_W-1:0]   left_idx;
    logic [IDX_W-1:0]   right_idx;
    logic [IDX_W-1:0]   count_ext;
    logic [ENTRY_W-1:0] cur_val;
    logic [CNT_W-1:0]   last_parent;

    assign req_stall  = (state_reg != ST_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign rsp_free   = !rsp_valid_reg || !rsp_stall;

    assign left_idx    = {1'b0, node_reg, 1'b1};
    assign right_idx   = left_idx + IDX_W'(1);
    assign count_ext   = IDX_W'(count_reg);
    assign last_parent = (count_reg - CNT_W'(2)) >> 1;

    // On the first level of a sift the node value arrives from memory; deeper
    // down it is held in val_reg while its old position stays stale.
    assign cur_val = first_reg ? rd_data_reg : val_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        shift_idx_next  = shift_idx_reg;
        node_next       = node_reg;
        root_next       = root_reg;
        first_next      = first_reg;
        right_ok_next   = right_ok_reg;
        val_next        = val_reg;
        left_next       = left_reg;
        op_status_next  = op_status_reg;
        op_prio_next    = op_prio_reg;
        op_tag_next     = op_tag_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rsp_status_next = rsp_status_reg;
        rsp_prio_next   = rsp_prio_reg;
        rsp_tag_next    = rsp_tag_reg;
        rsp_held_next   = rsp_held_reg;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = '0;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = '0;
        mem_wr_data     = val_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    op_status_next = STATUS_OK;
                    op_prio_next   = '0;
                    op_tag_next    = '0;
                    if (req_type == REQ_INSERT)
                    begin
                        if (count_reg >= CNT_W'(CAPACITY))
                        begin
                            op_status_next = STATUS_FULL;
                            state_next     = ST_FIN;
                        end
                        else
                        begin
                            // Append at the end, then rebuild.
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = count_reg[ADDR_W-1:0];
                            mem_wr_data = {entry_priority, entry_tag};
                            count_next  = count_reg + CNT_W'(1);
                            state_next  = ST_RB_GO;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            op_status_next = STATUS_EMPTY;
                            state_next     = ST_FIN;
                        end
                        else
                        begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = '0;
                            state_next  = ST_EX_LAT;
                        end
                    end
                end
            end

            ST_EX_LAT:
            begin
                // The root arrives; later entries then move down one place each.
                op_prio_next   = rd_data_reg[ENTRY_W-1:TAG_W];
                op_tag_next    = rd_data_reg[TAG_W-1:0];
                count_next     = count_reg - CNT_W'(1);
                shift_idx_next = CNT_W'(1);
                state_next     = (count_reg > CNT_W'(1)) ? ST_SH_RD : ST_RB_GO;
            end

            ST_SH_RD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = shift_idx_reg[ADDR_W-1:0];
                state_next  = ST_SH_WR;
            end

            ST_SH_WR:
            begin
                mem_wr_en      = 1'b1;
                mem_wr_addr    = ADDR_W'(shift_idx_reg - CNT_W'(1));
                mem_wr_data    = rd_data_reg;
                shift_idx_next = shift_idx_reg + CNT_W'(1);
                // count_reg already holds the reduced count, so the last index
                // to move is count_reg itself.
                state_next     = (shift_idx_reg < count_reg) ? ST_SH_RD : ST_RB_GO;
            end

            ST_RB_GO:
            begin
                if (count_reg < CNT_W'(2))
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    root_next  = ADDR_W'(last_parent);
                    node_next  = ADDR_W'(last_parent);
                    first_next = 1'b1;
                    state_next = ST_SD_RDN;
                end
            end

            ST_SD_RDN:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = node_reg;
                state_next  = ST_SD_RDL;
            end

            ST_SD_RDL:
            begin
                val_next   = cur_val;
                first_next = 1'b0;
                if (left_idx < count_ext)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = ADDR_W'(left_idx);
                    state_next  = ST_SD_RDR;
                end
                else
                begin
                    // Leaf reached: the travelling value settles here.
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = node_reg;
                    mem_wr_data = cur_val;
                    if (root_reg == '0)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        root_next  = root_reg - ADDR_W'(1);
                        node_next  = root_reg - ADDR_W'(1);
                        first_next = 1'b1;
                        state_next = ST_SD_RDN;
                    end
                end
            end

            ST_SD_RDR:
            begin
                left_next     = rd_data_reg;
                right_ok_next = (right_idx < count_ext);
                if (right_idx < count_ext)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = ADDR_W'(right_idx);
                end
                state_next = ST_SD_CMP;
            end

            ST_SD_CMP:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = node_reg;
                // Ties keep the node over its children and the left over the right.
                if (right_ok_reg
                    && (rd_data_reg[ENTRY_W-1:TAG_W] > left_reg[ENTRY_W-1:TAG_W])
                    && (rd_data_reg[ENTRY_W-1:TAG_W] > val_reg[ENTRY_W-1:TAG_W]))
                begin
                    mem_wr_data = rd_data_reg;
                    node_next   = ADDR_W'(right_idx);
                    state_next  = ST_SD_RDL;
                end
                else if (left_reg[ENTRY_W-1:TAG_W] > val_reg[ENTRY_W-1:TAG_W])
                begin
                    mem_wr_data = left_reg;
                    node_next   = ADDR_W'(left_idx);
                    state_next  = ST_SD_RDL;
                end
                else
                begin
                    mem_wr_data = val_reg;
                    if (root_reg == '0)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        root_next  = root_reg - ADDR_W'(1);
                        node_next  = root_reg - ADDR_W'(1);
                        first_next = 1'b1;
                        state_next = ST_SD_RDN;
                    end
                end
            end

            ST_FIN:
            begin
                // Hand the result to the output register once it is free.
                if (rsp_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = op_status_reg;
                    rsp_prio_next   = op_prio_reg;
                    rsp_tag_next    = op_tag_reg;
                    rsp_held_next   = HELD_W'(count_reg);
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        shift_idx_reg  <= shift_idx_next;
        node_reg       <= node_next;
        root_reg       <= root_next;
        first_reg      <= first_next;
        right_ok_reg   <= right_ok_next;
        val_reg        <= val_next;
        left_reg       <= left_next;
        op_status_reg  <= op_status_next;
        op_prio_reg    <= op_prio_next;
        op_tag_reg     <= op_tag_next;
        rsp_status_reg <= rsp_status_next;
        rsp_prio_reg   <= rsp_prio_next;
        rsp_tag_reg    <= rsp_tag_next;
        rsp_held_reg   <= rsp_held_next;
    end

    // Heap memory.
    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            heap_mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en)
        begin
            rd_data_reg <= heap_mem[mem_rd_addr];
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign status       = rsp_status_reg;
    assign out_priority = rsp_prio_reg;
    assign out_tag      = rsp_tag_reg;
    assign entries_held = rsp_held_reg;

    // The entry count never passes the capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // An accepted request always leaves the idle state.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_accept |=> state_reg != ST_IDLE)
        else $error("accepted request did not start");

    // The sequencer never reads and writes the same entry in one cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mem_wr_en && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr))
        else $error("memory read and write collide");

    // The count changes only on an accepted insert or on an extract.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> ($past(state_reg) == ST_IDLE || $past(state_reg) == ST_EX_LAT))
        else $error("entry count changed outside insert or extract");

endmodule

[tb/sv/max_heap_priority_queue_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_heap_priority_queue_checker
// Watches the request and response channels of the heap priority queue. It
// keeps its own copy of the heap, works out the response to every accepted
// request and compares each accepted response against the oldest one.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_checker
    import mhpq_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                req_valid,
    input  logic                req_stall,
    input  logic                req_type,
    input  logic [PRIO_W-1:0]   entry_priority,
    input  logic [TAG_W-1:0]    entry_tag,

    input  logic                rsp_valid,
    input  logic                rsp_stall,
    input  logic [STATUS_W-1:0] status,
    input  logic [PRIO_W-1:0]   out_priority,
    input  logic [TAG_W-1:0]    out_tag,
    input  logic [HELD_W-1:0]   entries_held,

    output int                  mismatches,
    output int                  results_seen
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PRIO_W-1:0]   prio;
        logic [TAG_W-1:0]    tag;
        logic [HELD_W-1:0]   held;
    } queue_result_t;

    // Model heap: priority in the upper half of each word, tag in the lower.
    logic [ENTRY_W-1:0] heap_model [CAPACITY];
    int unsigned        held_count;
    queue_result_t      pending_results [$];
    int                 failure_tally;

    function automatic logic [PRIO_W-1:0] prio_at(int unsigned idx);
        return heap_model[idx][ENTRY_W-1:TAG_W];
    endfunction

    function automatic void sift_entry_down(int unsigned node, int unsigned n);
        int unsigned        left_idx;
        int unsigned        right_idx;
        int unsigned        best;
        logic [ENTRY_W-1:0] swap_word;
        bit                 settled;
        settled = 1'b0;
        while (!settled)
        begin
            left_idx  = 2 * node + 1;
            right_idx = 2 * node + 2;
            best      = node;
            // Only a strictly greater child wins, and the left one is tried first.
            if (left_idx < n && prio_at(best) < prio_at(left_idx))
                best = left_idx;
            if (right_idx < n && prio_at(best) < prio_at(right_idx))
                best = right_idx;
            if (best == node)
            begin
                settled = 1'b1;
            end
            else
            begin
                swap_word        = heap_model[best];
                heap_model[best] = heap_model[node];
                heap_model[node] = swap_word;
                node             = best;
            end
        end
    endfunction

    function automatic void rebuild_heap(int unsigned n);
        if (n < 2)
            return;
        for (int i = int'((n - 2) / 2); i >= 0; i--)
            sift_entry_down(i, n);
    endfunction

    function automatic queue_result_t predict_request(logic kind, logic [PRIO_W-1:0] prio,
                                                      logic [TAG_W-1:0] tag);
        queue_result_t outcome;
        outcome        = '0;
        outcome.status = STATUS_OK;
        if (kind == REQ_INSERT)
        begin
            if (held_count >= CAPACITY)
            begin
                outcome.status = STATUS_FULL;
            end
            else
            begin
                heap_model[held_count] = {prio, tag};
                held_count++;
                rebuild_heap(held_count);
            end
        end
        else if (held_count == 0)
        begin
            outcome.status = STATUS_EMPTY;
        end
        else
        begin
            outcome.prio = heap_model[0][ENTRY_W-1:TAG_W];
            outcome.tag  = heap_model[0][TAG_W-1:0];
            for (int unsigned i = 1; i < held_count; i++)
                heap_model[i - 1] = heap_model[i];
            held_count--;
            rebuild_heap(held_count);
        end
        outcome.held = HELD_W'(held_count);
        return outcome;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        queue_result_t want;
        queue_result_t got;
        bit            wrong;
        if (!rst_n)
        begin
            held_count = 0;
            pending_results.delete();
            failure_tally = 0;
            mismatches   <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                got = '{status, out_priority, out_tag, entries_held};
                results_seen <= results_seen + 1;
                if (pending_results.size() == 0)
                begin
                    failure_tally++;
                    if (failure_tally <= 10)
                        $display("%0t: response with none outstanding: status %0d prio %h tag %h held %0d",
                                 $time, got.status, got.prio, got.tag, got.held);
                end
                else
                begin
                    want  = pending_results.pop_front();
                    wrong = (got.status !== want.status) || (got.prio !== want.prio) ||
                            (got.tag !== want.tag) || (got.held !== want.held);
                    if (wrong)
                    begin
                        failure_tally++;
                        if (failure_tally <= 10)
                            $display("%0t: expected status %0d prio %h tag %h held %0d, got status %0d prio %h tag %h held %0d",
                                     $time, want.status, want.prio, want.tag, want.held,
                                     got.status, got.prio, got.tag, got.held);
                    end
                end
            end
            if (req_valid && !req_stall)
                pending_results.push_back(predict_request(req_type, entry_priority, entry_tag));
            mismatches <= failure_tally;
        end
    end

endmodule

[tb/sv/max_heap_priority_queue_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_heap_priority_queue_top_test
// Drives insert and extract transactions into the heap priority queue with
// random gaps and response stalls. A directed opening covers the empty heap,
// extreme priorities and ties; random phases then fill, drain and churn the
// heap. The checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_top_test;
    import mhpq_pkg::*;

    // The run ends with a failure if it is still going after this many cycles.
    // It leaves headroom over the slowest legal transaction (an extract from a
    // full heap plus the rebuild) together with the random idle gaps that each
    // side may put between transactions.
    localparam int CYCLE_LIMIT  = 10_000_000;
    localparam int RANDOM_ITEMS = 2000;
    localparam int DRAIN_CYCLES = 1000;

    logic                clk;
    logic                rst_n;

    logic                req_valid;
    logic                req_stall;
    logic                req_type;
    logic [PRIO_W-1:0]   entry_priority;
    logic [TAG_W-1:0]    entry_tag;

    logic                rsp_valid;
    logic                rsp_stall;
    logic [STATUS_W-1:0] status;
    logic [PRIO_W-1:0]   out_priority;
    logic [TAG_W-1:0]    out_tag;
    logic [HELD_W-1:0]   entries_held;

    int                  mismatches;
    int                  results_seen;
    int                  requests_sent;
    int                  cycle_count;
    int                  stall_budget;
    bit                  sender_burst;
    bit                  receiver_burst;

    max_heap_priority_queue_top DUT
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .req_type       (req_type),
        .entry_priority (entry_priority),
        .entry_tag      (entry_tag),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .status         (status),
        .out_priority   (out_priority),
        .out_tag        (out_tag),
        .entries_held   (entries_held)
    );

    // The checker sees exactly what the block sees on both channels.
    max_heap_priority_queue_checker checker_inst
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .req_type       (req_type),
        .entry_priority (entry_priority),
        .entry_tag      (entry_tag),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .status         (status),
        .out_priority   (out_priority),
        .out_tag        (out_tag),
        .entries_held   (entries_held),
        .mismatches     (mismatches),
        .results_seen   (results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog. A hung handshake ends the run here instead of spinning forever.
    initial
    begin
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Response side. After each accepted response a new stall budget is drawn;
    // it is spent only while a response is offered, so stalls land both on
    // the first cycle a response appears and in the middle of a wait. Burst
    // stretches with no stalls at all come and go at random.
    initial
    begin
        stall_budget   = 0;
        receiver_burst = 1'b0;
        rsp_stall     <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rsp_valid && !rsp_stall)
        begin
            if ($urandom_range(0, 39) == 0)
                receiver_burst = !receiver_burst;
            stall_budget = receiver_burst ? 0 : $urandom_range(0, 19);
        end
        else if (rsp_valid && stall_budget > 0)
        begin
            stall_budget--;
        end
        rsp_stall <= (stall_budget > 0);
    end

    // Offers one request transaction and returns at the edge where it is taken.
    // A gap of zero keeps valid high straight into the next transaction, so the
    // block sees back-to-back requests as well as idle cycles in between.
    task automatic send_request(logic kind, logic [PRIO_W-1:0] prio, logic [TAG_W-1:0] tag);
        int gap;
        if ($urandom_range(0, 39) == 0)
            sender_burst = !sender_burst;
        gap = sender_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid      <= 1'b1;
        req_type       <= kind;
        entry_priority <= prio;
        entry_tag      <= tag;
        do
            @(posedge clk);
        while (req_stall);
        requests_sent++;
    endtask

    // Priorities are drawn from a narrow band a quarter of the time so that
    // equal priorities meet in the heap and the tie rules get exercised, and
    // the two extreme values show up often.
    function automatic logic [PRIO_W-1:0] draw_priority();
        case ($urandom_range(0, 3))
            0:       return PRIO_W'($urandom_range(0, 7));
            1:       return ($urandom_range(0, 1) != 0) ? '1 : '0;
            default: return PRIO_W'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    initial
    begin
        int  phase_idx;
        int  phase_len;
        int  insert_pct;
        int  random_sent;
        logic kind;

        requests_sent  = 0;
        sender_burst   = 1'b0;
        rst_n          = 1'b0;
        req_valid     <= 1'b0;
        req_type      <= REQ_INSERT;
        entry_priority <= '0;
        entry_tag     <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening. An extract before anything is stored must come
        // back empty with zero payload.
        send_request(REQ_EXTRACT, 16'h1234, 16'hABCD);

        // Extreme priorities and tags, then several equal priorities with
        // different tags so that the order among ties becomes visible when
        // they are pulled out again.
        send_request(REQ_INSERT, 16'h0000, 16'h0000);
        send_request(REQ_INSERT, 16'hFFFF, 16'hFFFF);
        send_request(REQ_INSERT, 16'h8000, 16'h1234);
        send_request(REQ_INSERT, 16'h8000, 16'h5678);
        send_request(REQ_INSERT, 16'h8000, 16'h9ABC);
        send_request(REQ_INSERT, 16'h0001, 16'hFFFE);
        send_request(REQ_INSERT, 16'hFFFF, 16'h0001);
        send_request(REQ_INSERT, 16'h7FFF, 16'hA5A5);

        // Drain everything, then one more extract on the now empty heap.
        repeat (9) send_request(REQ_EXTRACT, 16'hFFFF, 16'hFFFF);

        // A single entry in and out exercises the heap with one element.
        send_request(REQ_INSERT, 16'h5A5A, 16'h5A5A);
        send_request(REQ_EXTRACT, 16'h0000, 16'h0000);

        // Random phases. The first phase fills the heap well past its
        // capacity so inserts get rejected as full, the second drains it past
        // empty. After that phases of fill, drain and mixed traffic alternate
        // so the heap size wanders over its whole range.
        phase_idx   = 0;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            if (phase_idx == 0)
            begin
                insert_pct = 95;
                phase_len  = 90;
            end
            else if (phase_idx == 1)
            begin
                insert_pct = 5;
                phase_len  = 90;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:       insert_pct = 90;
                    1:       insert_pct = 10;
                    default: insert_pct = 55;
                endcase
                phase_len = $urandom_range(20, 120);
            end
            for (int k = 0; k < phase_len && random_sent < RANDOM_ITEMS; k++)
            begin
                kind = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_EXTRACT;
                send_request(kind, draw_priority(), TAG_W'($urandom_range(0, 16'hFFFF)));
                random_sent++;
            end
            phase_idx++;
        end
        req_valid <= 1'b0;

        // Every request produces exactly one response. Wait for all of them,
        // then keep watching a while for anything unexpected.
        while (results_seen != requests_sent)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
